@@ design/spkcbc_pkg.sv @@
package spkcbc_pkg;

  // Word and rotation constants of Speck128/128
  localparam int WORD_W    = 64;
  localparam int ROT_A     = 8;
  localparam int ROT_B     = 3;
  localparam int CFG_IDX_W = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEY_FIRST  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_SECOND = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IV_LEFT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IV_RIGHT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DECRYPT    = 3'd4;

  typedef logic [WORD_W-1:0] word_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic expand;
    logic round;
    logic finish;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic exp_last;
    logic rnd_last;
  } dp_status_t;

  function automatic word_t ror64(input word_t v, input int unsigned s);
    return (v >> s) | (v << (WORD_W - s));
  endfunction

  function automatic word_t rol64(input word_t v, input int unsigned s);
    return (v << s) | (v >> (WORD_W - s));
  endfunction

endpackage

@@ design/spkcbc_in_if.sv @@
interface spkcbc_in_if;
  logic                        valid;
  logic                        ready;
  logic [spkcbc_pkg::WORD_W-1:0] block_left;
  logic [spkcbc_pkg::WORD_W-1:0] block_right;
  logic                        first_block;

  modport source (output valid, output block_left, output block_right,
                  output first_block, input ready);
  modport sink   (input valid, input block_left, input block_right,
                  input first_block, output ready);
endinterface

@@ design/spkcbc_out_if.sv @@
interface spkcbc_out_if;
  logic                        valid;
  logic                        ready;
  logic [spkcbc_pkg::WORD_W-1:0] out_left;
  logic [spkcbc_pkg::WORD_W-1:0] out_right;

  modport source (output valid, output out_left, output out_right, input ready);
  modport sink   (input valid, input out_left, input out_right, output ready);
endinterface

@@ design/spkcbc_cfg_if.sv @@
interface spkcbc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [spkcbc_pkg::CFG_IDX_W-1:0] index;
  logic [spkcbc_pkg::WORD_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ design/spkcbc_ram.sv @@
module spkcbc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ design/spkcbc_dp.sv @@
module spkcbc_dp #(
  parameter int ROUND_COUNT = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [spkcbc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [spkcbc_pkg::WORD_W-1:0]    cfg_data,
  input  logic [spkcbc_pkg::WORD_W-1:0]    in_left,
  input  logic [spkcbc_pkg::WORD_W-1:0]    in_right,
  input  logic                           in_first,
  input  spkcbc_pkg::ctrl_cmd_t          cmd,
  output spkcbc_pkg::dp_status_t         status,
  output logic [spkcbc_pkg::WORD_W-1:0]    out_left,
  output logic [spkcbc_pkg::WORD_W-1:0]    out_right
);
  import spkcbc_pkg::*;

  localparam int RIDX_W = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;
  localparam int CNT_W  = $clog2(ROUND_COUNT + 1);
  localparam logic [RIDX_W-1:0] LAST_IDX = RIDX_W'(ROUND_COUNT - 1);
  localparam logic [CNT_W-1:0]  EXP_END  = CNT_W'(ROUND_COUNT - 1);
  localparam logic [CNT_W-1:0]  RND_END  = CNT_W'(ROUND_COUNT);

  // Configuration registers
  word_t key_first_r, key_second_r, iv_left_r, iv_right_r;
  logic  decrypt_cfg_r;

  // Chain and working registers
  word_t chain_left_r, chain_right_r;
  word_t x_r, y_r, k_r, l_r, pend_left_r, pend_right_r;
  word_t out_left_r, out_right_r;
  logic  decrypt_r;
  logic [CNT_W-1:0] cnt_r;

  word_t cl, cr, l_nxt, k_nxt, enc_x, enc_y, dec_x, dec_y, rkey;
  word_t res_left, res_right;
  logic  rnd_apply;
  logic [RIDX_W-1:0] rd_addr;

  // Take configuration writes; ignore indexes beyond the list
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_first_r   <= '0;
      key_second_r  <= '0;
      iv_left_r     <= '0;
      iv_right_r    <= '0;
      decrypt_cfg_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KEY_FIRST:  key_first_r   <= cfg_data;
        REG_KEY_SECOND: key_second_r  <= cfg_data;
        REG_IV_LEFT:    iv_left_r     <= cfg_data;
        REG_IV_RIGHT:   iv_right_r    <= cfg_data;
        REG_DECRYPT:    decrypt_cfg_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Pick the chain for this item
  assign cl = in_first ? iv_left_r  : chain_left_r;
  assign cr = in_first ? iv_right_r : chain_right_r;

  // One key schedule step
  assign l_nxt = (ror64(l_r, ROT_A) + k_r) ^ WORD_W'(cnt_r);
  assign k_nxt = rol64(k_r, ROT_B) ^ l_nxt;

  // Round key read: forward order to encrypt, reverse to decrypt
  assign rd_addr = decrypt_r ? (LAST_IDX - cnt_r[RIDX_W-1:0]) : cnt_r[RIDX_W-1:0];

  spkcbc_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ROUND_COUNT)
  ) u_rk_ram (
    .clk   (clk),
    .we    (cmd.expand),
    .waddr (cnt_r[RIDX_W-1:0]),
    .wdata (k_r),
    .raddr (rd_addr),
    .rdata (rkey)
  );

  // Forward and inverse round
  assign enc_x = (ror64(x_r, ROT_A) + y_r) ^ rkey;
  assign enc_y = rol64(y_r, ROT_B) ^ enc_x;
  assign dec_y = ror64(y_r ^ x_r, ROT_B);
  assign dec_x = rol64((x_r ^ rkey) - dec_y, ROT_A);

  // Read data is registered, so round zero applies at count one
  assign rnd_apply = cmd.round && (cnt_r != '0);

  assign res_left  = decrypt_r ? (y_r ^ pend_left_r)  : y_r;
  assign res_right = decrypt_r ? (x_r ^ pend_right_r) : x_r;

  // Round counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.load) begin
      cnt_r <= '0;
    end else if (cmd.expand) begin
      cnt_r <= status.exp_last ? '0 : cnt_r + 1'b1;
    end else if (cmd.round) begin
      cnt_r <= status.rnd_last ? '0 : cnt_r + 1'b1;
    end
  end

  // Chain: ciphertext just seen, in either direction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_left_r  <= '0;
      chain_right_r <= '0;
    end else if (cmd.load && decrypt_cfg_r) begin
      chain_left_r  <= in_left;
      chain_right_r <= in_right;
    end else if (cmd.finish && !decrypt_r) begin
      chain_left_r  <= y_r;
      chain_right_r <= x_r;
    end
  end

  // Block, key schedule and result registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      decrypt_r    <= decrypt_cfg_r;
      k_r          <= key_first_r;
      l_r          <= key_second_r;
      pend_left_r  <= cl;
      pend_right_r <= cr;
      if (decrypt_cfg_r) begin
        y_r <= in_left;
        x_r <= in_right;
      end else begin
        y_r <= in_left ^ cl;
        x_r <= in_right ^ cr;
      end
    end
    if (cmd.expand) begin
      k_r <= k_nxt;
      l_r <= l_nxt;
    end
    if (rnd_apply) begin
      x_r <= decrypt_r ? dec_x : enc_x;
      y_r <= decrypt_r ? dec_y : enc_y;
    end
    if (cmd.finish) begin
      out_left_r  <= res_left;
      out_right_r <= res_right;
    end
  end

  assign status.exp_last = (cnt_r == EXP_END);
  assign status.rnd_last = (cnt_r == RND_END);
  assign out_left  = out_left_r;
  assign out_right = out_right_r;

endmodule

@@ design/spkcbc_ctrl.sv @@
module spkcbc_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  spkcbc_pkg::dp_status_t status,
  output spkcbc_pkg::ctrl_cmd_t  cmd
);
  import spkcbc_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_EXPAND = 2'd1;
  localparam logic [1:0] S_ROUND  = 2'd2;
  localparam logic [1:0] S_DONE   = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  // Sequence one item: expand keys, run rounds, hand over the result
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = rst_n;
        if (in_valid && rst_n) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXPAND;
        end
      end
      S_EXPAND: begin
        cmd.expand = 1'b1;
        if (status.exp_last) begin
          state_nxt = S_ROUND;
        end
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        if (status.rnd_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output register: fill on finish, drop when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_accept_expands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_EXPAND))
    else $error("accepted item did not start key expansion");

  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_valid_r || out_ready))
    else $error("result overwrote an untaken result");

  a_rounds_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROUND && status.rnd_last) |=> (state_r == S_DONE))
    else $error("last round did not lead to hand-over");

  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result shown without a finished item");

endmodule

@@ design/speck_cbc_block_cipher_top.sv @@
// Speck128/128 block cipher in CBC mode.
// in_ch carries one 128-bit block per item (block_left is the y word,
// block_right the x word) and first_block, which restarts the chain from the
// IV registers. out_ch returns one block per item, in order.
// cfg_ch writes the registers: 0 key first word, 1 key second word,
// 2 IV left, 3 IV right, 4 decrypt mode; other indexes are ignored. It is
// ready whenever reset is released; write it only while no item is in flight.
// Each item runs from acceptance to the next acceptance through the key
// schedule, one round key written per cycle into the round key RAM, then the
// rounds through the single round unit fed by the RAM's registered read, then
// the load of the output register once it is free, and an idle state to
// accept. The result appears on out_ch once loaded into the output register.
// A finished result waits in the output register; the next item is accepted
// meanwhile, and its result is held in the datapath until the register frees.
// Synchronous reset clears the registers, the chain and the control state;
// no item or register write is taken while reset is held.
module speck_cbc_block_cipher_top #(
  parameter int ROUND_COUNT = 32
) (
  input logic          clk,
  input logic          rst_n,
  spkcbc_in_if.sink    in_ch,
  spkcbc_out_if.source out_ch,
  spkcbc_cfg_if.sink   cfg_ch
);
  import spkcbc_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ch.ready = rst_n;

  spkcbc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  spkcbc_dp #(
    .ROUND_COUNT (ROUND_COUNT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_ch.valid && cfg_ch.ready),
    .cfg_index (cfg_ch.index),
    .cfg_data  (cfg_ch.data),
    .in_left   (in_ch.block_left),
    .in_right  (in_ch.block_right),
    .in_first  (in_ch.first_block),
    .cmd       (cmd),
    .status    (status),
    .out_left  (out_ch.out_left),
    .out_right (out_ch.out_right)
  );

endmodule
